>>> design/c8_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// c8_pkg
// Shared types, opcode fields, fault codes and the font table of the
// CHIP-8 instruction core.
// ============================================================================
package c8_pkg;

    localparam int MEM_BYTES     = 4096;
    localparam int ADDR_W        = 12;
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int ROW_W         = 5;
    localparam int COL_W         = 6;
    localparam int STACK_DEF     = 16;
    localparam int FONT_BYTES    = 80;
    localparam int IN_W          = 64;
    localparam int OUT_W         = 32;

    localparam logic [ADDR_W-1:0] PC_RESET = 12'h200;

    // item kinds
    localparam logic [2:0] ITEM_EXEC = 3'd0;
    localparam logic [2:0] ITEM_TICK = 3'd1;
    localparam logic [2:0] ITEM_MWR  = 3'd2;
    localparam logic [2:0] ITEM_MRD  = 3'd3;
    localparam logic [2:0] ITEM_PIX  = 3'd4;

    // fault codes
    localparam logic [1:0] FLT_OK    = 2'd0;
    localparam logic [1:0] FLT_BAD   = 2'd1;
    localparam logic [1:0] FLT_OVER  = 2'd2;
    localparam logic [1:0] FLT_UNDER = 2'd3;

    // opcode groups (top nibble)
    localparam logic [3:0] GRP_SYS  = 4'h0;
    localparam logic [3:0] GRP_JP   = 4'h1;
    localparam logic [3:0] GRP_CALL = 4'h2;
    localparam logic [3:0] GRP_SE   = 4'h3;
    localparam logic [3:0] GRP_SNE  = 4'h4;
    localparam logic [3:0] GRP_SEV  = 4'h5;
    localparam logic [3:0] GRP_LD   = 4'h6;
    localparam logic [3:0] GRP_ADD  = 4'h7;
    localparam logic [3:0] GRP_ALU  = 4'h8;
    localparam logic [3:0] GRP_SNEV = 4'h9;
    localparam logic [3:0] GRP_LDI  = 4'hA;
    localparam logic [3:0] GRP_JPV  = 4'hB;
    localparam logic [3:0] GRP_RND  = 4'hC;
    localparam logic [3:0] GRP_DRW  = 4'hD;
    localparam logic [3:0] GRP_KEY  = 4'hE;

    localparam logic [15:0] OPC_CLS = 16'h00E0;
    localparam logic [15:0] OPC_RET = 16'h00EE;

    localparam logic [7:0] KEY_SKP  = 8'h9E;
    localparam logic [7:0] KEY_SKNP = 8'hA1;

    localparam logic [7:0] FX_LDDT = 8'h07;
    localparam logic [7:0] FX_WKEY = 8'h0A;
    localparam logic [7:0] FX_SDT  = 8'h15;
    localparam logic [7:0] FX_SST  = 8'h18;
    localparam logic [7:0] FX_ADDI = 8'h1E;
    localparam logic [7:0] FX_FONT = 8'h29;
    localparam logic [7:0] FX_BCD  = 8'h33;
    localparam logic [7:0] FX_STR  = 8'h55;
    localparam logic [7:0] FX_LDR  = 8'h65;

    // 8xy low nibble
    localparam logic [3:0] ALU_LD   = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_TICK, S_MWR, S_MRD, S_MRD2, S_PRD, S_PRD2,
        S_F0, S_F1, S_F2, S_F3, S_F4, S_EXEC, S_WRX, S_CLS,
        S_SPR_A, S_SPR_B, S_SPR_C, S_SPR_D, S_BCD0, S_BCD1, S_BCD2,
        S_ST_A, S_ST_B, S_LD_A, S_LD_B, S_DONE
    } t_state;

    typedef struct packed {
        logic [7:0] res;
        logic       flag;
        logic       flagged;
        logic       valid;
    } t_alu_out;

    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    function automatic logic [7:0] font_byte(input logic [ADDR_W-1:0] a);
        logic [7:0] b;
        b = 8'd0;
        if (a < ADDR_W'(FONT_BYTES)) begin
            b = FONT[a[6:0]];
        end
        return b;
    endfunction

endpackage

>>> design/c8_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// c8_ram
// Single-port synchronous RAM, registered read data.
// ============================================================================
module c8_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_addr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    output logic [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] mem [P_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        o_rdata <= mem[i_addr];
    end

endmodule

>>> design/c8_alu.sv
`timescale 1ns / 1ps
// ============================================================================
// c8_alu
// 8xyN register operations with VF flag.
// ============================================================================
module c8_alu (
    input  logic             [3:0] i_fn,
    input  logic             [7:0] i_vx,
    input  logic             [7:0] i_vy,
    output c8_pkg::t_alu_out       o_alu
);
    import c8_pkg::*;

    logic [8:0] sum;

    assign sum = {1'b0, i_vx} + {1'b0, i_vy};

    always_comb begin
        o_alu = '{res: 8'd0, flag: 1'b0, flagged: 1'b0, valid: 1'b1};
        case (i_fn)
            ALU_LD:   o_alu.res = i_vy;
            ALU_OR:   o_alu.res = i_vx | i_vy;
            ALU_AND:  o_alu.res = i_vx & i_vy;
            ALU_XOR:  o_alu.res = i_vx ^ i_vy;
            ALU_ADD: begin
                o_alu.res = sum[7:0];
                o_alu.flag = sum[8];
                o_alu.flagged = 1'b1;
            end
            ALU_SUB: begin
                o_alu.res = i_vx - i_vy;
                o_alu.flag = i_vx > i_vy;
                o_alu.flagged = 1'b1;
            end
            ALU_SHR: begin
                o_alu.res = {1'b0, i_vx[7:1]};
                o_alu.flag = i_vx[0];
                o_alu.flagged = 1'b1;
            end
            ALU_SUBN: begin
                o_alu.res = i_vy - i_vx;
                o_alu.flag = i_vy > i_vx;
                o_alu.flagged = 1'b1;
            end
            ALU_SHL: begin
                o_alu.res = {i_vx[6:0], 1'b0};
                o_alu.flag = i_vx[7];
                o_alu.flagged = 1'b1;
            end
            default: o_alu.valid = 1'b0;
        endcase
    end

endmodule

>>> design/chip8_instruction_core_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// chip8_instruction_core_unit
// CHIP-8 core: instruction execute, timer tick, memory and pixel access.
// ============================================================================
// After reset the core runs an initialization pass over all of main memory
// (font loaded at its base, the rest cleared; screen and V registers cleared)
// and accepts no transfer until it ends. Items are handled one at a time
// through single-port memories for main memory, the screen (32 rows of 64
// pixels) and V0..VF. A plain instruction fetches its two bytes, then reads
// Vx and Vy, then executes. Longer ones: CLS clears all 32 screen rows, DRW
// XORs one sprite byte into the screen per sprite row, LD [I],Vx and
// LD Vx,[I] move one register per step from V0 to Vx, BCD writes three
// digits. The next item is accepted while a result waits on the output.
module chip8_instruction_core_unit #(
    parameter int STACK_DEPTH = c8_pkg::STACK_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // op[2:0] keypad[18:3] random_byte[26:19] mem_addr[38:27]
    // mem_data[46:39] pixel_index[57:47]
    input  logic [c8_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // pc_now[11:0] read_byte[19:12] pixel_on[20] key_wait[21]
    // sound_active[22] fault[24:23]
    output logic [c8_pkg::OUT_W-1:0]  m_axis_tdata
);
    import c8_pkg::*;

    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int SPI_W = $clog2(STACK_DEPTH);

    t_state r_state, n_state;

    logic [15:0]       r_keys;
    logic [7:0]        r_rnd;
    logic [ADDR_W-1:0] r_maddr;
    logic [7:0]        r_mdata;
    logic [10:0]       r_pix;

    logic [ADDR_W-1:0] r_pc, r_i;
    logic [SP_W-1:0]   r_sp;
    logic [7:0]        r_dt, r_st;
    logic [ADDR_W-1:0] r_stack [STACK_DEPTH];

    logic [15:0]       r_opc;
    logic [7:0]        r_vx, r_vy;
    logic [ADDR_W-1:0] r_cnt;
    logic              r_hit;
    logic [7:0]        r_byte, r_wval;
    logic [6:0]        r_bcd_a;
    logic [3:0]        r_bcd_b;
    logic              r_wait;
    logic [1:0]        r_fault;
    logic [7:0]        r_rd;
    logic              r_pon;
    logic              r_ovalid;
    logic [OUT_W-1:0]  r_odata;

    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_addr;
    logic [7:0]               mem_wdata, mem_rdata;
    logic                     fb_we;
    logic [ROW_W-1:0]         fb_addr;
    logic [SCREEN_WIDTH-1:0]  fb_wdata, fb_rdata;
    logic                     rf_we;
    logic [3:0]               rf_addr;
    logic [7:0]               rf_wdata, rf_rdata;

    logic              accept, slot_free;
    logic [3:0]        grp, ox, oy, on;
    logic [7:0]        kk;
    logic [ADDR_W-1:0] nnn, pc_next, pc_skip, stack_top;
    logic [SP_W-1:0]   sp_dec;
    t_alu_out          alu;
    logic [3:0]        key_idx;
    logic              held;

    logic [1:0]        e_fault;
    logic [ADDR_W-1:0] e_npc;
    logic              e_wait;
    t_state            e_goto;
    logic              e_rwe;
    logic [3:0]        e_rwaddr;
    logic [7:0]        e_rwdata;

    logic [SCREEN_WIDTH-1:0] spr_mask;
    logic [13:0]             bcd_h_full;
    logic [1:0]              bcd_h;
    logic [14:0]             bcd_t_full;
    logic [3:0]              bcd_t;
    logic [ROW_W-1:0]        spr_row;

    c8_ram #(.P_WIDTH(8), .P_DEPTH(MEM_BYTES)) u_mem (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(mem_addr),
        .i_wdata(mem_wdata), .o_rdata(mem_rdata)
    );

    c8_ram #(.P_WIDTH(SCREEN_WIDTH), .P_DEPTH(SCREEN_HEIGHT)) u_fb (
        .i_clk(i_clk), .i_we(fb_we), .i_addr(fb_addr),
        .i_wdata(fb_wdata), .o_rdata(fb_rdata)
    );

    c8_ram #(.P_WIDTH(8), .P_DEPTH(16)) u_rf (
        .i_clk(i_clk), .i_we(rf_we), .i_addr(rf_addr),
        .i_wdata(rf_wdata), .o_rdata(rf_rdata)
    );

    c8_alu u_alu (.i_fn(on), .i_vx(r_vx), .i_vy(r_vy), .o_alu(alu));

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !r_ovalid || m_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    assign grp       = r_opc[15:12];
    assign ox        = r_opc[11:8];
    assign oy        = r_opc[7:4];
    assign on        = r_opc[3:0];
    assign kk        = r_opc[7:0];
    assign nnn       = r_opc[11:0];
    assign pc_next   = r_pc + ADDR_W'(2);
    assign pc_skip   = r_pc + ADDR_W'(4);
    assign sp_dec    = r_sp - SP_W'(1);
    assign stack_top = r_stack[sp_dec[SPI_W-1:0]];
    assign held      = r_keys[r_vx[3:0]];
    assign spr_row   = r_vy[ROW_W-1:0] + r_cnt[ROW_W-1:0];

    assign bcd_h_full = 14'(r_vx) * 14'd41;
    assign bcd_h      = bcd_h_full[13:12];
    assign bcd_t_full = 15'(r_bcd_a) * 15'd205;
    assign bcd_t      = bcd_t_full[14:11];

    always_comb begin
        key_idx = 4'd0;
        for (int k = 15; k >= 0; k--) begin
            if (r_keys[k]) begin
                key_idx = 4'(k);
            end
        end
    end

    always_comb begin
        logic [COL_W-1:0] col;
        spr_mask = '0;
        for (int c = 0; c < 8; c++) begin
            col = r_vx[COL_W-1:0] + COL_W'(c);
            if (r_byte[7-c]) begin
                spr_mask[col] = 1'b1;
            end
        end
    end

    // instruction decode
    always_comb begin
        e_fault  = FLT_OK;
        e_npc    = pc_next;
        e_wait   = 1'b0;
        e_goto   = S_DONE;
        e_rwe    = 1'b0;
        e_rwaddr = ox;
        e_rwdata = 8'd0;
        case (grp)
            GRP_SYS: begin
                if (r_opc == OPC_CLS) begin
                    e_goto = S_CLS;
                end else if (r_opc == OPC_RET) begin
                    if (r_sp == '0) begin
                        e_fault = FLT_UNDER;
                    end else begin
                        e_npc = stack_top + ADDR_W'(2);
                    end
                end else begin
                    e_fault = FLT_BAD;
                end
            end
            GRP_JP: e_npc = nnn;
            GRP_CALL: begin
                if (r_sp >= SP_W'(STACK_DEPTH)) begin
                    e_fault = FLT_OVER;
                end else begin
                    e_npc = nnn;
                end
            end
            GRP_SE: begin
                if (r_vx == kk) e_npc = pc_skip;
            end
            GRP_SNE: begin
                if (r_vx != kk) e_npc = pc_skip;
            end
            GRP_SEV: begin
                if (on != 4'd0) e_fault = FLT_BAD;
                else if (r_vx == r_vy) e_npc = pc_skip;
            end
            GRP_SNEV: begin
                if (on != 4'd0) e_fault = FLT_BAD;
                else if (r_vx != r_vy) e_npc = pc_skip;
            end
            GRP_LD: begin
                e_rwe = 1'b1;
                e_rwdata = kk;
            end
            GRP_ADD: begin
                e_rwe = 1'b1;
                e_rwdata = r_vx + kk;
            end
            GRP_ALU: begin
                if (!alu.valid) begin
                    e_fault = FLT_BAD;
                end else if (alu.flagged) begin
                    e_rwe = 1'b1;
                    e_rwaddr = 4'hF;
                    e_rwdata = {7'd0, alu.flag};
                    e_goto = S_WRX;
                end else begin
                    e_rwe = 1'b1;
                    e_rwdata = alu.res;
                end
            end
            GRP_LDI: e_npc = pc_next;
            GRP_JPV: e_npc = ADDR_W'(r_vy) + nnn;
            GRP_RND: begin
                e_rwe = 1'b1;
                e_rwdata = r_rnd & kk;
            end
            GRP_DRW: begin
                if (on == 4'd0) begin
                    e_rwe = 1'b1;
                    e_rwaddr = 4'hF;
                end else begin
                    e_goto = S_SPR_A;
                end
            end
            GRP_KEY: begin
                if (kk == KEY_SKP) begin
                    if (held) e_npc = pc_skip;
                end else if (kk == KEY_SKNP) begin
                    if (!held) e_npc = pc_skip;
                end else begin
                    e_fault = FLT_BAD;
                end
            end
            default: begin
                case (kk)
                    FX_LDDT: begin
                        e_rwe = 1'b1;
                        e_rwdata = r_dt;
                    end
                    FX_WKEY: begin
                        if (r_keys == 16'd0) begin
                            e_wait = 1'b1;
                            e_npc = r_pc;
                        end else begin
                            e_rwe = 1'b1;
                            e_rwdata = {4'd0, key_idx};
                        end
                    end
                    FX_SDT, FX_SST, FX_ADDI, FX_FONT: e_npc = pc_next;
                    FX_BCD: e_goto = S_BCD0;
                    FX_STR: e_goto = S_ST_A;
                    FX_LDR: e_goto = S_LD_A;
                    default: e_fault = FLT_BAD;
                endcase
            end
        endcase
        if (e_fault != FLT_OK) begin
            e_rwe  = 1'b0;
            e_wait = 1'b0;
            e_goto = S_DONE;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (r_cnt == '1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    case (s_axis_tdata[2:0])
                        ITEM_EXEC: n_state = S_F0;
                        ITEM_TICK: n_state = S_TICK;
                        ITEM_MWR:  n_state = S_MWR;
                        ITEM_MRD:  n_state = S_MRD;
                        ITEM_PIX:  n_state = S_PRD;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_TICK, S_MWR: n_state = S_DONE;
            S_MRD:   n_state = S_MRD2;
            S_MRD2:  n_state = S_DONE;
            S_PRD:   n_state = S_PRD2;
            S_PRD2:  n_state = S_DONE;
            S_F0:    n_state = S_F1;
            S_F1:    n_state = S_F2;
            S_F2:    n_state = S_F3;
            S_F3:    n_state = S_F4;
            S_F4:    n_state = S_EXEC;
            S_EXEC:  n_state = e_goto;
            S_WRX:   n_state = S_DONE;
            S_CLS: begin
                if (r_cnt[ROW_W-1:0] == '1) n_state = S_DONE;
            end
            S_SPR_A: n_state = S_SPR_B;
            S_SPR_B: n_state = S_SPR_C;
            S_SPR_C: begin
                n_state = (r_cnt[3:0] == on - 4'd1) ? S_SPR_D : S_SPR_A;
            end
            S_SPR_D: n_state = S_DONE;
            S_BCD0:  n_state = S_BCD1;
            S_BCD1:  n_state = S_BCD2;
            S_BCD2:  n_state = S_DONE;
            S_ST_A:  n_state = S_ST_B;
            S_ST_B:  n_state = (r_cnt[3:0] == ox) ? S_DONE : S_ST_A;
            S_LD_A:  n_state = S_LD_B;
            S_LD_B:  n_state = (r_cnt[3:0] == ox) ? S_DONE : S_LD_A;
            S_DONE: begin
                if (slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_pc;
        mem_wdata = 8'd0;
        fb_we     = 1'b0;
        fb_addr   = spr_row;
        fb_wdata  = '0;
        rf_we     = 1'b0;
        rf_addr   = ox;
        rf_wdata  = 8'd0;
        case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_addr  = r_cnt;
                mem_wdata = font_byte(r_cnt);
                fb_we     = (r_cnt < ADDR_W'(SCREEN_HEIGHT));
                fb_addr   = r_cnt[ROW_W-1:0];
                rf_we     = (r_cnt < ADDR_W'(16));
                rf_addr   = r_cnt[3:0];
            end
            S_MWR: begin
                mem_we    = 1'b1;
                mem_addr  = r_maddr;
                mem_wdata = r_mdata;
            end
            S_MRD:  mem_addr = r_maddr;
            S_PRD:  fb_addr  = r_pix[10:COL_W];
            S_F1:   mem_addr = pc_next - ADDR_W'(1);
            S_F3:   rf_addr  = (grp == GRP_JPV) ? 4'd0 : oy;
            S_EXEC: begin
                rf_we    = e_rwe;
                rf_addr  = e_rwaddr;
                rf_wdata = e_rwdata;
            end
            S_WRX: begin
                rf_we    = 1'b1;
                rf_wdata = r_wval;
            end
            S_CLS: begin
                fb_we   = 1'b1;
                fb_addr = r_cnt[ROW_W-1:0];
            end
            S_SPR_A: mem_addr = r_i + r_cnt;
            S_SPR_C: begin
                fb_we    = 1'b1;
                fb_wdata = fb_rdata ^ spr_mask;
            end
            S_SPR_D: begin
                rf_we    = 1'b1;
                rf_addr  = 4'hF;
                rf_wdata = {7'd0, r_hit};
            end
            S_BCD0: begin
                mem_we    = 1'b1;
                mem_addr  = r_i;
                mem_wdata = {6'd0, bcd_h};
            end
            S_BCD1: begin
                mem_we    = 1'b1;
                mem_addr  = r_i + ADDR_W'(1);
                mem_wdata = {4'd0, bcd_t};
            end
            S_BCD2: begin
                mem_we    = 1'b1;
                mem_addr  = r_i + ADDR_W'(2);
                mem_wdata = {4'd0, r_bcd_b};
            end
            S_ST_A: rf_addr = r_cnt[3:0];
            S_ST_B: begin
                mem_we    = 1'b1;
                mem_addr  = r_i + r_cnt;
                mem_wdata = rf_rdata;
            end
            S_LD_A: mem_addr = r_i + r_cnt;
            S_LD_B: begin
                rf_we    = 1'b1;
                rf_addr  = r_cnt[3:0];
                rf_wdata = mem_rdata;
            end
            default: mem_addr = r_pc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_cnt    <= '0;
            r_pc     <= PC_RESET;
            r_i      <= '0;
            r_sp     <= '0;
            r_dt     <= 8'd0;
            r_st     <= 8'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && slot_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLR: r_cnt <= r_cnt + ADDR_W'(1);
                S_IDLE: begin
                    if (accept) begin
                        r_keys  <= s_axis_tdata[18:3];
                        r_rnd   <= s_axis_tdata[26:19];
                        r_maddr <= s_axis_tdata[38:27];
                        r_mdata <= s_axis_tdata[46:39];
                        r_pix   <= s_axis_tdata[57:47];
                        r_rd    <= 8'd0;
                        r_pon   <= 1'b0;
                        r_wait  <= 1'b0;
                        r_fault <= FLT_OK;
                    end
                end
                S_TICK: begin
                    if (r_dt != 8'd0) r_dt <= r_dt - 8'd1;
                    if (r_st != 8'd0) r_st <= r_st - 8'd1;
                end
                S_MRD2: r_rd  <= mem_rdata;
                S_PRD2: r_pon <= fb_rdata[r_pix[COL_W-1:0]];
                S_F1:   r_opc[15:8] <= mem_rdata;
                S_F2:   r_opc[7:0]  <= mem_rdata;
                S_F3:   r_vx <= rf_rdata;
                S_F4:   r_vy <= rf_rdata;
                S_EXEC: begin
                    r_fault <= e_fault;
                    r_cnt   <= '0;
                    r_hit   <= 1'b0;
                    r_wval  <= alu.res;
                    if (e_fault == FLT_OK) begin
                        r_pc   <= e_npc;
                        r_wait <= e_wait;
                        case (grp)
                            GRP_SYS: begin
                                if (r_opc == OPC_RET) r_sp <= sp_dec;
                            end
                            GRP_CALL: begin
                                r_stack[r_sp[SPI_W-1:0]] <= r_pc;
                                r_sp <= r_sp + SP_W'(1);
                            end
                            GRP_LDI: r_i <= nnn;
                            default: begin
                                if (grp == 4'hF) begin
                                    case (kk)
                                        FX_SDT:  r_dt <= r_vx;
                                        FX_SST:  r_st <= r_vx;
                                        FX_ADDI: r_i  <= r_i + ADDR_W'(r_vx);
                                        FX_FONT: r_i  <= {2'd0, r_vx, 2'd0}
                                                         + ADDR_W'(r_vx);
                                        default: ;
                                    endcase
                                end
                            end
                        endcase
                    end
                end
                S_CLS:   r_cnt <= r_cnt + ADDR_W'(1);
                S_SPR_B: r_byte <= mem_rdata;
                S_SPR_C: begin
                    r_hit <= r_hit | (|(fb_rdata & spr_mask));
                    r_cnt <= r_cnt + ADDR_W'(1);
                end
                S_BCD0: r_bcd_a <= 7'(r_vx - 8'(bcd_h) * 8'd100);
                S_BCD1: r_bcd_b <= 4'(r_bcd_a - 7'(bcd_t) * 7'd10);
                S_ST_B, S_LD_B: r_cnt <= r_cnt + ADDR_W'(1);
                S_DONE: begin
                    if (slot_free) begin
                        r_odata  <= {7'd0, r_fault, (r_st != 8'd0), r_wait,
                                     r_pon, r_rd, r_pc};
                    end
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
